// ----- sv/i2p_pkg.sv -----
package i2p_pkg;

  // Operator stack geometry.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned STACK_CW    = $clog2(STACK_DEPTH + 1);

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    K_COPY   = 3'd0,
    K_OPEN   = 3'd1,
    K_OPER   = 3'd2,
    K_CLOSE  = 3'd3,
    K_IGNORE = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [1:0] prec;
    logic       sep;
    logic       eoe;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       expr_done;
    err_e       error_code;
    logic       last_of_run;
  } result_t;

  // Binding strength of an operator; zero for anything else.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    case (c)
      CH_CARET:                   p = 2'd3;
      CH_STAR, CH_SLASH, CH_PCT:  p = 2'd2;
      CH_PLUS, CH_MINUS:          p = 2'd1;
      default:                    p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/i2p_if.sv -----
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic [7:0] next_char;
  logic       end_of_expr;

  modport source (output valid, output in_char, output next_char, output end_of_expr,
                  input ready);
  modport sink (input valid, input in_char, input next_char, input end_of_expr,
                output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       expr_done;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_char, output char_valid, output expr_done,
                  output error_code, output last_of_run, input ready);
  modport sink (input valid, input out_char, input char_valid, input expr_done,
                input error_code, input last_of_run, output ready);
endinterface

// ----- sv/infix_to_postfix_converter.sv -----
// Channel  Dir  Carries                                   Transfer when
// in_i     in   in_char, next_char, end_of_expr            valid & ready
// out_o    out  out_char, char_valid, expr_done,           valid & ready
//               error_code, last_of_run
//
// In the back, a digit or space, a '(' and a ')' that finds its '(' on top pass
// through dispatch, work, end check and finish. An operator adds a step to see
// that its pop run is over and another for a separating space, and an ignored
// character skips the work step. Every popped stack entry adds a step of its own.
// Reset is asynchronous and active low and empties the stack and the queue.
// The front fills a two-entry queue; the back stalls only on full result registers.
module infix_to_postfix_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2p_in_if.sink    in_i,
  i2p_out_if.source out_o
);
  import i2p_pkg::*;

  // Classified characters from the front, and the same after the queue.
  cmd_req_t front_cmd;
  cmd_req_t queue_cmd;
  logic     queue_ready;
  logic     back_ready;

  // The front classifies each character and works out whether an operator
  // needs a separating space, since that depends only on the input order.
  i2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_ready_i (queue_ready)
  );

  // The queue lets the front take new characters while a long pop run of an
  // earlier one is still going on in the back.
  i2p_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_cmd),
    .push_ready_o (queue_ready),
    .pop_o        (queue_cmd),
    .pop_ready_i  (back_ready)
  );

  // The back owns the operator stack and produces at most one result per cycle.
  // Each result waits in a hold register until the next result or the finish step
  // shows if it was the last of its character, then moves to the output register.
  i2p_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

// ----- sv/i2p_front.sv -----
module i2p_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2p_in_if.sink             in_i,
  output i2p_pkg::cmd_req_t  cmd_o,
  input  logic               cmd_ready_i
);
  import i2p_pkg::*;

  logic [7:0] prev_q, prev_d;
  logic       accept;
  logic [1:0] prec;
  kind_e      kind;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid & cmd_ready_i;
  assign prec       = prec_of(in_i.in_char);

  always_comb begin
    if ((in_i.in_char >= CH_ZERO && in_i.in_char <= CH_NINE) || in_i.in_char == CH_SPACE) begin
      kind = K_COPY;
    end else if (in_i.in_char == CH_LPAR) begin
      kind = K_OPEN;
    end else if (prec != 2'd0) begin
      kind = K_OPER;
    end else if (in_i.in_char == CH_RPAR) begin
      kind = K_CLOSE;
    end else begin
      kind = K_IGNORE;
    end
  end

  always_comb begin
    cmd_o.valid    = in_i.valid;
    cmd_o.cmd.kind = kind;
    cmd_o.cmd.ch   = in_i.in_char;
    cmd_o.cmd.prec = prec;
    cmd_o.cmd.sep  = (prev_q != CH_SPACE) && (in_i.next_char != CH_SPACE);
    cmd_o.cmd.eoe  = in_i.end_of_expr;
  end

  // The previous character restarts as a space after every expression.
  always_comb begin
    prev_d = prev_q;
    if (accept) begin
      prev_d = in_i.end_of_expr ? CH_SPACE : in_i.in_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= CH_SPACE;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ----- sv/i2p_queue.sv -----
module i2p_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2p_pkg::cmd_req_t  push_i,
  output logic               push_ready_o,
  output i2p_pkg::cmd_req_t  pop_o,
  input  logic               pop_ready_i
);
  import i2p_pkg::*;

  cmd_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                push, pop;

  assign push_ready_o = count_q != QUEUE_CW'(QUEUE_DEPTH);
  assign push         = push_i.valid & push_ready_o;
  assign pop_o.valid  = count_q != '0;
  assign pop_o.cmd    = entry_q[rd_ptr_q];
  assign pop          = pop_ready_i & pop_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ----- sv/i2p_back.sv -----
module i2p_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2p_pkg::cmd_req_t  cmd_i,
  output logic               cmd_ready_o,
  i2p_out_if.source          out_o
);
  import i2p_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_COPY  = 8'b0000_0010,
    S_SEP   = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_PUSH  = 8'b0001_0000,
    S_CLOSE = 8'b0010_0000,
    S_END   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cmd_q;
  logic                cmd_load;

  logic [7:0]          mem [STACK_DEPTH];
  logic [STACK_CW-1:0] cnt_q, cnt_d;
  logic [7:0]          top_q, rd_q, top;
  logic                top_rd_q, top_rd_d;
  logic [STACK_AW-1:0] rd_addr;
  logic                do_push, do_pop, has_top, full;

  result_t             hold_q, out_q, emit_res, fin_res;
  logic                hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;
  logic                emit, fin_load, move, out_free, can_emit;

  // The top entry lives in top_q after a push and in rd_q after a pop.
  assign top      = top_rd_q ? rd_q : top_q;
  assign has_top  = cnt_q != '0;
  assign full     = cnt_q == STACK_CW'(STACK_DEPTH);
  assign rd_addr  = STACK_AW'(cnt_q - STACK_CW'(2));
  assign out_free = !out_valid_q || out_o.ready;
  assign can_emit = !hold_valid_q || out_free;
  assign move     = fin_load || (emit && hold_valid_q);

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    cmd_load    = 1'b0;
    emit        = 1'b0;
    emit_res    = '{out_char: CH_NUL, char_valid: 1'b0, expr_done: 1'b0,
                    error_code: ERR_NONE, last_of_run: 1'b0};
    fin_load    = 1'b0;
    fin_res     = hold_q;
    do_push     = 1'b0;
    do_pop      = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_i.valid) begin
          cmd_load = 1'b1;
          case (cmd_i.cmd.kind)
            K_COPY:  state_d = S_COPY;
            K_OPEN:  state_d = S_PUSH;
            K_OPER:  state_d = cmd_i.cmd.sep ? S_SEP : S_POP;
            K_CLOSE: state_d = S_CLOSE;
            default: state_d = S_END;
          endcase
        end
      end
      S_COPY: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_res.out_char   = cmd_q.ch;
          emit_res.char_valid = 1'b1;
          state_d             = S_END;
        end
      end
      S_SEP: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_res.out_char   = CH_SPACE;
          emit_res.char_valid = 1'b1;
          state_d             = S_POP;
        end
      end
      S_POP: begin
        if (has_top && prec_of(top) >= cmd_q.prec) begin
          if (can_emit) begin
            emit                = 1'b1;
            do_pop              = 1'b1;
            emit_res.out_char   = top;
            emit_res.char_valid = 1'b1;
          end
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full) begin
          do_push = 1'b1;
          state_d = S_END;
        end else if (can_emit) begin
          emit                = 1'b1;
          emit_res.error_code = ERR_OVERFLOW;
          state_d             = S_END;
        end
      end
      S_CLOSE: begin
        if (has_top && top != CH_LPAR) begin
          if (can_emit) begin
            emit                = 1'b1;
            do_pop              = 1'b1;
            emit_res.out_char   = top;
            emit_res.char_valid = 1'b1;
          end
        end else if (has_top) begin
          do_pop  = 1'b1;
          state_d = S_END;
        end else if (can_emit) begin
          emit                = 1'b1;
          emit_res.error_code = ERR_UNMATCHED;
          state_d             = S_END;
        end
      end
      S_END: begin
        if (cmd_q.eoe && has_top) begin
          if (can_emit) begin
            emit                = 1'b1;
            do_pop              = 1'b1;
            emit_res.out_char   = top;
            emit_res.char_valid = 1'b1;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        fin_res.last_of_run = 1'b1;
        fin_res.expr_done   = cmd_q.eoe;
        if (hold_valid_q) begin
          if (out_free) begin
            fin_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (cmd_q.eoe) begin
          fin_res.out_char   = CH_NUL;
          fin_res.char_valid = 1'b0;
          fin_res.error_code = ERR_NONE;
          if (out_free) begin
            fin_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    top_rd_d = top_rd_q;
    if (do_push) begin
      cnt_d    = cnt_q + 1'b1;
      top_rd_d = 1'b0;
    end else if (do_pop) begin
      cnt_d    = cnt_q - 1'b1;
      top_rd_d = 1'b1;
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (emit) begin
      hold_valid_d = 1'b1;
    end else if (fin_load) begin
      hold_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && !out_o.ready;
    if (move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      top_rd_q     <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      top_rd_q     <= top_rd_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      cmd_q <= cmd_i.cmd;
    end
    if (emit) begin
      hold_q <= emit_res;
    end
    if (fin_load) begin
      out_q <= fin_res;
    end else if (emit && hold_valid_q) begin
      out_q <= hold_q;
    end
  end

  // Stack memory: one write on a push, one registered read on a pop.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[cnt_q[STACK_AW-1:0]] <= cmd_q.ch;
      top_q                    <= cmd_q.ch;
    end
    if (do_pop) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = out_q.out_char;
  assign out_o.char_valid  = out_q.char_valid;
  assign out_o.expr_done   = out_q.expr_done;
  assign out_o.error_code  = out_q.error_code;
  assign out_o.last_of_run = out_q.last_of_run;

endmodule

// ----- sv/i2p_checker.sv -----
module i2p_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       char_valid_i,
  input logic       expr_done_i,
  input logic [1:0] error_code_i,
  input logic       last_of_run_i
);
  import i2p_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(char_valid_i) && $stable(expr_done_i) && $stable(error_code_i)
      && $stable(last_of_run_i))
    else $error("result changed while stalled");

  a_empty_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |-> out_char_i == CH_NUL)
    else $error("result without a character carries a nonzero code");

  a_err_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != ERR_NONE |-> !char_valid_i)
    else $error("error result carries a character");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && expr_done_i |-> last_of_run_i)
    else $error("expression end is not the last result of its character");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .char_valid_i  (out_o.char_valid),
  .expr_done_i   (out_o.expr_done),
  .error_code_i  (out_o.error_code),
  .last_of_run_i (out_o.last_of_run)
);

// ----- tb/sv/postfix_scoreboard.sv -----
module postfix_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  i2p_in_if    in_mon_i,
  i2p_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  import i2p_pkg::*;

  // Shadow copy of the operator stack and the lookbehind character.
  logic [7:0]  op_stack [STACK_DEPTH];
  int unsigned op_depth;
  logic [7:0]  prev_char;

  result_t     burst_q[$];
  result_t     postfix_q[$];
  int          fault_count;

  function automatic logic [1:0] bind_strength(input logic [7:0] c);
    logic [1:0] s;
    s = 2'd0;
    if (c == CH_CARET) begin
      s = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
      s = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      s = 2'd1;
    end
    return s;
  endfunction

  function automatic void add_result(input logic [7:0] ch, input logic vld, input err_e err);
    result_t r;
    r.out_char    = ch;
    r.char_valid  = vld;
    r.expr_done   = 1'b0;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void pop_to_output();
    op_depth--;
    add_result(op_stack[op_depth], 1'b1, ERR_NONE);
  endfunction

  // A full stack drops the new entry and reports it instead.
  function automatic void push_operator(input logic [7:0] c);
    if (op_depth < STACK_DEPTH) begin
      op_stack[op_depth] = c;
      op_depth++;
    end else begin
      add_result(CH_NUL, 1'b0, ERR_OVERFLOW);
    end
  endfunction

  function automatic void predict_postfix(input logic [7:0] c, input logic [7:0] nx,
                                          input logic eoe);
    logic [1:0] strength;
    strength = bind_strength(c);
    burst_q.delete();
    if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE) begin
      add_result(c, 1'b1, ERR_NONE);
    end else if (c == CH_LPAR) begin
      push_operator(c);
    end else if (strength != 2'd0) begin
      if (prev_char != CH_SPACE && nx != CH_SPACE) begin
        add_result(CH_SPACE, 1'b1, ERR_NONE);
      end
      while (op_depth > 0 && bind_strength(op_stack[op_depth - 1]) >= strength) begin
        pop_to_output();
      end
      push_operator(c);
    end else if (c == CH_RPAR) begin
      while (op_depth > 0 && op_stack[op_depth - 1] != CH_LPAR) begin
        pop_to_output();
      end
      if (op_depth > 0) begin
        op_depth--;
      end else begin
        add_result(CH_NUL, 1'b0, ERR_UNMATCHED);
      end
    end
    prev_char = c;
    if (eoe) begin
      while (op_depth > 0) begin
        pop_to_output();
      end
      if (burst_q.size() == 0) begin
        add_result(CH_NUL, 1'b0, ERR_NONE);
      end
      burst_q[burst_q.size() - 1].expr_done = 1'b1;
      prev_char = CH_SPACE;
    end
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].last_of_run = 1'b1;
    end
    foreach (burst_q[i]) begin
      postfix_q.push_back(burst_q[i]);
    end
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.out_char    = out_mon_i.out_char;
    got.char_valid  = out_mon_i.char_valid;
    got.expr_done   = out_mon_i.expr_done;
    got.error_code  = err_e'(out_mon_i.error_code);
    got.last_of_run = out_mon_i.last_of_run;
    if (postfix_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("[%0t] unexpected result: char %h valid %b done %b err %0d last %b",
                 $realtime, got.out_char, got.char_valid, got.expr_done,
                 got.error_code, got.last_of_run);
      end
    end else begin
      want = postfix_q.pop_front();
      if (got !== want) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("[%0t] mismatch: char %h/%h valid %b/%b done %b/%b err %0d/%0d last %b/%b",
                   $realtime, want.out_char, got.out_char, want.char_valid, got.char_valid,
                   want.expr_done, got.expr_done, want.error_code, got.error_code,
                   want.last_of_run, got.last_of_run);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_depth = 0;
      prev_char = CH_SPACE;
      postfix_q.delete();
      fault_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon_i.valid === 1'b1 && in_mon_i.ready === 1'b1) begin
        predict_postfix(in_mon_i.in_char, in_mon_i.next_char, in_mon_i.end_of_expr);
      end
      if (out_mon_i.valid === 1'b1 && out_mon_i.ready === 1'b1) begin
        check_result();
      end
      pending_o <= int'(postfix_q.size());
      fail_count_o <= fault_count;
    end
  end

endmodule

// ----- tb/sv/tb_infix_to_postfix_converter.sv -----
// Stimulus and verdict for the infix to postfix converter. The scoreboard
// instance beside the block watches both channels, predicts every result and
// counts failures; this module only produces traffic and decides the outcome.
module tb_infix_to_postfix_converter;
  import i2p_pkg::*;

  typedef logic [7:0] text_t[$];

  // The slowest legal run is far below this: a few hundred items, each at
  // most 19 results with a receiver stall apiece, plus the long hold.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned RANDOM_ITEMS = 260;
  localparam int unsigned SETTLE       = 64;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  i2p_in_if  in_if();
  i2p_out_if out_if();

  int fail_count;
  int pending;

  // When set, neither side inserts idle cycles.
  bit steady_flow;
  // Request from the stimulus to the receiver for one long hold-off.
  bit long_hold_req;
  int unsigned accepted_items;

  always #1 clk_i = ~clk_i;

  infix_to_postfix_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  postfix_scoreboard scoreboard_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver. After every transfer it draws a stall length at random, or none when
  // the flow is steady. A long hold request overrides the draw, so the block's result
  // registers and its command queue fill up and the input side has to stall.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        stall_left = steady_flow ? 0 : $urandom_range(0, 4);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  // Watchdog. Reaching the limit means the block hung somewhere.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] pick_operator();
    logic [7:0] op;
    case ($urandom_range(0, 5))
      0:       op = CH_PLUS;
      1:       op = CH_MINUS;
      2:       op = CH_STAR;
      3:       op = CH_SLASH;
      4:       op = CH_PCT;
      default: op = CH_CARET;
    endcase
    return op;
  endfunction

  function automatic text_t text_of(input string s);
    text_t t;
    foreach (s[i]) begin
      t.push_back(s[i]);
    end
    return t;
  endfunction

  // A well-formed expression: numbers joined by operators, with optional
  // spaces around operators and balanced parentheses up to max_nest deep.
  function automatic text_t build_expression(input int unsigned max_nest);
    text_t t;
    int unsigned open;
    int unsigned terms;
    open = 0;
    terms = $urandom_range(1, 6);
    for (int unsigned k = 0; k < terms; k++) begin
      while (open < max_nest && $urandom_range(0, 3) == 0) begin
        t.push_back(CH_LPAR);
        open++;
      end
      repeat ($urandom_range(1, 3)) t.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        t.push_back(CH_RPAR);
        open--;
      end
      if (k + 1 < terms) begin
        if ($urandom_range(0, 2) == 0) t.push_back(CH_SPACE);
        t.push_back(pick_operator());
        if ($urandom_range(0, 2) == 0) t.push_back(CH_SPACE);
      end
    end
    repeat (open) t.push_back(CH_RPAR);
    return t;
  endfunction

  // Nesting near or past the stack depth. The closing count is off by a
  // little most of the time, which leaves either '(' for the final flush or
  // unmatched ')' behind.
  function automatic text_t build_deep_nest();
    text_t t;
    text_t inner;
    int unsigned n;
    n = $urandom_range(10, STACK_DEPTH + 2);
    repeat (n) t.push_back(CH_LPAR);
    inner = build_expression(0);
    foreach (inner[i]) t.push_back(inner[i]);
    repeat ($urandom_range(n - 1, n + 2)) t.push_back(CH_RPAR);
    return t;
  endfunction

  function automatic bit bind_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_LPAR || c == CH_RPAR || c == CH_PLUS ||
           c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_PCT ||
           c == CH_CARET;
  endfunction

  // One transfer on the input channel, after a random gap unless the flow
  // is steady. Valid stays high between back-to-back items.
  task automatic send_char(input logic [7:0] c, input logic [7:0] nx, input logic eoe);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.in_char     <= c;
    in_if.next_char   <= nx;
    in_if.end_of_expr <= eoe;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    // Characters the block simply drops do not count toward the item budget.
    if (eoe || (c >= CH_ZERO && c <= CH_NINE) || bind_char(c)) begin
      accepted_items++;
    end
  endtask

  // Sends a whole expression with its lookahead; the last character carries
  // a zero lookahead and the end mark.
  task automatic send_expr(input text_t t);
    foreach (t[i]) begin
      if (i == t.size() - 1) begin
        send_char(t[i], CH_NUL, 1'b1);
      end else begin
        send_char(t[i], t[i + 1], 1'b0);
      end
    end
  endtask

  // Broken traffic: arbitrary bytes and lookaheads and stray end marks,
  // closed by an end mark so the next expression starts clean.
  task automatic send_noise(input int unsigned count);
    logic [7:0] c;
    logic [7:0] nx;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0:       c = pick_operator();
        1:       c = $urandom_range(0, 1) ? CH_LPAR : CH_RPAR;
        2:       c = 8'(CH_ZERO + $urandom_range(0, 9));
        default: c = 8'($urandom_range(0, 255));
      endcase
      nx = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255));
      send_char(c, nx, (k + 1 == count) || ($urandom_range(0, 5) == 0));
    end
  endtask

  // Lowers valid and waits until every predicted result has been seen. At
  // least one edge passes so the scoreboard's count covers the last transfer.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    text_t t;
    int unsigned random_start;
    int unsigned pick;

    in_if.valid       <= 1'b0;
    in_if.in_char     <= CH_NUL;
    in_if.next_char   <= CH_NUL;
    in_if.end_of_expr <= 1'b0;
    steady_flow   = 1'b0;
    long_hold_req = 1'b0;
    accepted_items = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Every operator, both digit extremes, a space next to an
    // operator, separators inserted where neither neighbor is a space, and
    // a parenthesized group.
    send_expr(text_of("0^9 %(1*2/3)-4+5"));
    // A closing parenthesis with nothing open.
    send_char(CH_RPAR, CH_NUL, 1'b1);
    // Fill the stack with '(' so that both a further '(' and an operator hit
    // the overflow; the end then flushes sixteen entries in one burst.
    t.delete();
    repeat (STACK_DEPTH + 1) t.push_back(CH_LPAR);
    t.push_back(CH_CARET);
    send_expr(t);
    // Byte extremes on both character fields; the first is ignored, the
    // second ends an expression that produced nothing.
    send_char(8'hFF, 8'hFF, 1'b0);
    send_char(CH_NUL, 8'hFF, 1'b1);
    wait_for_drain();

    // Back pressure: the receiver holds off while the sender keeps offering
    // a steady stream, so the block has to stall its input.
    steady_flow = 1'b1;
    long_hold_req = 1'b1;
    send_expr(build_expression(3));
    send_expr(build_deep_nest());
    send_expr(build_expression(3));
    steady_flow = 1'b0;
    wait_for_drain();

    // Random part, mostly well-formed expressions with some deep nesting and
    // some broken traffic. Stretches of steady flow are mixed in.
    random_start = accepted_items;
    while (accepted_items - random_start < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_expr(build_expression(3));
      end else if (pick < 16) begin
        send_expr(build_deep_nest());
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_for_drain();
      end
    end
    steady_flow = 1'b0;

    wait_for_drain();
    repeat (SETTLE) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/i2p_pkg.sv
sv/i2p_if.sv
sv/i2p_front.sv
sv/i2p_queue.sv
sv/i2p_back.sv
sv/infix_to_postfix_converter.sv
sv/i2p_checker.sv
tb/sv/postfix_scoreboard.sv
tb/sv/tb_infix_to_postfix_converter.sv
